### sv/psg_pkg.sv
// ----------------------------------------------------------------------------
// Prime sieve generator package
// Shared constants, state encoding and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package psg_pkg;

    localparam int PRIME_COUNT_W = 16;
    localparam int SIEVE_LIMIT_W = 17;
    localparam int CFG_DATA_W    = 17;
    localparam int CFG_INDEX_W   = 1;
    localparam int PRIME_W       = 16;
    localparam int INDEX_W       = 16;

    localparam int ROW_W = 32;
    localparam int BIT_W = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRIME_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIEVE_LIMIT = 1'd1;

    localparam logic [PRIME_COUNT_W-1:0] PRIME_COUNT_RESET = 16'd1024;
    localparam logic [SIEVE_LIMIT_W-1:0] SIEVE_LIMIT_RESET = 17'd65536;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_SQUARE,
        ST_MARK_RD,
        ST_MARK_WR
    } state_t;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic rd_cand;
        logic cand_inc;
        logic take_prime;
        logic emit_done;
        logic square;
        logic rd_k;
        logic wr_k;
        logic cand_next;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic found_ge_count;
        logic cand_ge_limit;
        logic bit_marked;
        logic k_ge_limit;
        logic out_free;
    } dp_status_t;

endpackage

### sv/psg_ctrl.sv
// ----------------------------------------------------------------------------
// Prime sieve generator controller
// Sequences the clearing sweep, the candidate scan and the marking loop.
// ----------------------------------------------------------------------------
module psg_ctrl
    import psg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       restart,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   restart_pend_reg;
    logic   restart_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            restart_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            restart_pend_reg <= restart_pend_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        restart_pend_next = restart_pend_reg;
        cmd               = '0;
        in_ready          = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    restart_pend_next = 1'b0;
                    state_next        = restart_pend_reg ? ST_CHECK : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (restart)
                    begin
                        cmd.clr_start     = 1'b1;
                        restart_pend_next = 1'b1;
                        state_next        = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.found_ge_count || status.cand_ge_limit)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_done = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_cand = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.bit_marked)
                begin
                    cmd.cand_inc = 1'b1;
                    state_next   = ST_CHECK;
                end
                else if (status.out_free)
                begin
                    cmd.take_prime = 1'b1;
                    state_next     = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_MARK_RD;
            end
            ST_MARK_RD:
            begin
                if (status.k_ge_limit)
                begin
                    cmd.cand_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.rd_k   = 1'b1;
                    state_next = ST_MARK_WR;
                end
            end
            ST_MARK_WR:
            begin
                cmd.wr_k   = 1'b1;
                state_next = ST_MARK_RD;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### sv/psg_dp.sv
// ----------------------------------------------------------------------------
// Prime sieve generator datapath
// Holds the composite bitmap, the candidate and prime counters, the
// configuration registers, the marking stride and the result register.
// ----------------------------------------------------------------------------
module psg_dp
    import psg_pkg::*;
#(
    parameter int SIEVE_SIZE = 65536
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PRIME_W-1:0]     prime,
    output logic                   done_res,
    output logic [INDEX_W-1:0]     prime_index
);

    localparam int CAND_W = $clog2(SIEVE_SIZE + 1);
    localparam int KW     = 2 * CAND_W;
    localparam int ROWS   = (SIEVE_SIZE + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = ROW_AW + BIT_W;
    localparam int LW     = (CAND_W > SIEVE_LIMIT_W) ? CAND_W : SIEVE_LIMIT_W;

    logic [PRIME_COUNT_W-1:0] prime_count_reg;
    logic [SIEVE_LIMIT_W-1:0] sieve_limit_reg;

    logic [CAND_W-1:0]        cand_reg;
    logic [INDEX_W-1:0]       found_reg;
    logic [ROW_AW-1:0]        clr_cnt_reg;
    logic [CAND_W-1:0]        p_reg;
    logic [KW-1:0]            k_reg;

    logic                     out_valid_reg;
    logic [PRIME_W-1:0]       prime_reg;
    logic                     done_reg;
    logic [INDEX_W-1:0]       index_reg;

    logic [ROW_W-1:0]         mark_mem [ROWS];
    logic [ROW_W-1:0]         rd_data_reg;

    logic [LW-1:0]            limit_ext;
    logic [CAND_W-1:0]        eff_limit;
    logic [IDX_W-1:0]         cand_idx;
    logic [IDX_W-1:0]         k_idx;
    logic                     mem_we;
    logic [ROW_AW-1:0]        mem_wa;
    logic [ROW_W-1:0]         mem_wd;
    logic                     mem_re;
    logic [ROW_AW-1:0]        mem_ra;

    assign limit_ext = LW'(sieve_limit_reg);
    assign eff_limit = (limit_ext > LW'(SIEVE_SIZE)) ? CAND_W'(SIEVE_SIZE)
                                                     : CAND_W'(limit_ext);
    assign cand_idx  = IDX_W'(cand_reg);
    assign k_idx     = IDX_W'(k_reg);

    assign status.clr_last       = (clr_cnt_reg == ROW_AW'(ROWS - 1));
    assign status.found_ge_count = (found_reg >= prime_count_reg);
    assign status.cand_ge_limit  = (cand_reg >= eff_limit);
    assign status.bit_marked     = rd_data_reg[cand_idx[BIT_W-1:0]];
    assign status.k_ge_limit     = (k_reg >= KW'(eff_limit));
    assign status.out_free       = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_count_reg <= PRIME_COUNT_RESET;
            sieve_limit_reg <= SIEVE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRIME_COUNT: prime_count_reg <= cfg_data[PRIME_COUNT_W-1:0];
                CFG_SIEVE_LIMIT: sieve_limit_reg <= cfg_data[SIEVE_LIMIT_W-1:0];
                default:         prime_count_reg <= prime_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg    <= CAND_W'(2);
            found_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clr_start)
            begin
                cand_reg    <= CAND_W'(2);
                found_reg   <= '0;
                clr_cnt_reg <= '0;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.cand_inc)
            begin
                cand_reg <= cand_reg + 1'b1;
            end
            if (cmd.cand_next)
            begin
                cand_reg <= p_reg + 1'b1;
            end
            if (cmd.take_prime)
            begin
                found_reg <= found_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_prime)
        begin
            p_reg <= cand_reg;
        end
        if (cmd.square)
        begin
            k_reg <= KW'(p_reg) * KW'(p_reg);
        end
        else if (cmd.wr_k)
        begin
            k_reg <= k_reg + KW'(p_reg);
        end
    end

    always_comb
    begin
        mem_we = cmd.clr_step || cmd.wr_k;
        mem_wa = cmd.clr_step ? clr_cnt_reg : k_idx[IDX_W-1:BIT_W];
        mem_wd = cmd.clr_step ? '0
                              : (rd_data_reg | (ROW_W'(1) << k_idx[BIT_W-1:0]));
        mem_re = cmd.rd_cand || cmd.rd_k;
        mem_ra = cmd.rd_cand ? cand_idx[IDX_W-1:BIT_W] : k_idx[IDX_W-1:BIT_W];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mark_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mark_mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.take_prime || cmd.emit_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_prime)
        begin
            prime_reg <= PRIME_W'(cand_reg);
            done_reg  <= 1'b0;
            index_reg <= found_reg;
        end
        else if (cmd.emit_done)
        begin
            prime_reg <= '0;
            done_reg  <= 1'b1;
            index_reg <= '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign prime       = prime_reg;
    assign done_res    = done_reg;
    assign prime_index = index_reg;

endmodule

### sv/prime_sieve_generator_top.sv
// ----------------------------------------------------------------------------
// Prime sieve generator
// Sieve of Eratosthenes that returns the next prime for each request.
// ----------------------------------------------------------------------------
// After reset and after every request with restart set, the bitmap is cleared
// one 32-bit row per cycle; no request is taken during the reset sweep. For a
// request, each candidate examined first reads its row from the bitmap and then
// tests the bit. Once a prime p is found the result transfer is offered at once,
// and the block squares p and then marks the multiples of p from p*p up to the
// limit, each by a read and a write back of one row, before it leaves the loop.
// ----------------------------------------------------------------------------
module prime_sieve_generator_top
    import psg_pkg::*;
#(
    parameter int SIEVE_SIZE = 65536
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   restart,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PRIME_W-1:0]     prime,
    output logic                   done_res,
    output logic [INDEX_W-1:0]     prime_index
);

    dp_cmd_t    cmd;
    dp_status_t status;

    psg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .status   (status),
        .cmd      (cmd)
    );

    psg_dp #(
        .SIEVE_SIZE (SIEVE_SIZE)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .prime       (prime),
        .done_res    (done_res),
        .prime_index (prime_index)
    );

    // The controller works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("Request taken while the previous one is still in progress.");

    // A done answer carries neither a prime nor a position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (prime == '0 && prime_index == '0))
        else $error("Done result with a nonzero prime or position.");

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_prime || cmd.emit_done) |-> (!out_valid || out_ready))
        else $error("Result register overwritten before its transfer.");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime sieve generator testbench
// Sends next-prime requests over the valid/ready handshake, reprograms the
// prime count and sieve limit between phases, and checks every result
// transfer against a sieve kept alongside the block with the same marks,
// candidate and found count.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [psg_pkg::PRIME_W-1:0] prime;
    logic                        finished;
    logic [psg_pkg::INDEX_W-1:0] position;
} sieve_answer_t;

class sieve_tracker #(int unsigned SIEVE_SIZE = 65536);
    bit            marked[SIEVE_SIZE];
    int unsigned   candidate;
    int unsigned   found;
    int unsigned   count_reg;
    int unsigned   limit_reg;
    int unsigned   settle_cycles;
    int unsigned   errors;
    sieve_answer_t awaited_primes[$];

    function void clear_run();
        foreach (marked[i])
            marked[i] = 1'b0;
        candidate = 2;
        found     = 0;
    endfunction

    function void reset_state();
        clear_run();
        count_reg     = psg_pkg::PRIME_COUNT_RESET;
        limit_reg     = psg_pkg::SIEVE_LIMIT_RESET;
        settle_cycles = 0;
        errors        = 0;
        awaited_primes.delete();
    endfunction

    function void write_reg(logic [psg_pkg::CFG_INDEX_W-1:0] idx,
                            logic [psg_pkg::CFG_DATA_W-1:0] data);
        if (idx == psg_pkg::CFG_PRIME_COUNT)
            count_reg = data[psg_pkg::PRIME_COUNT_W-1:0];
        else if (idx == psg_pkg::CFG_SIEVE_LIMIT)
            limit_reg = data;
    endfunction

    function void predict_next_prime(bit clear_first);
        int unsigned     lim;
        int unsigned     p;
        longint unsigned k;
        sieve_answer_t   ans;
        lim = (limit_reg > SIEVE_SIZE) ? SIEVE_SIZE : limit_reg;
        if (clear_first)
            clear_run();
        if (found < count_reg)
            while (candidate < lim && marked[candidate % SIEVE_SIZE])
                candidate++;
        if (found >= count_reg || candidate >= lim) begin
            ans           = '{prime: '0, finished: 1'b1, position: '0};
            settle_cycles = 16;
        end
        else begin
            p             = candidate;
            ans.prime     = p[15:0];
            ans.finished  = 1'b0;
            ans.position  = found[15:0];
            found         = (found + 1) & 32'h0000_FFFF;
            settle_cycles = 64;
            k             = p;
            k             = k * p;
            while (k < lim) begin
                marked[k % SIEVE_SIZE] = 1'b1;
                settle_cycles += 2;
                k += p;
            end
            candidate = (p + 1) & 32'h0001_FFFF;
        end
        awaited_primes = {awaited_primes, ans};
    endfunction

    function void check_prime_transfer(sieve_answer_t got);
        sieve_answer_t want;
        if (awaited_primes.size() == 0) begin
            errors++;
            $display("%0t: result transfer with nothing expected, prime %0d done %0d index %0d",
                     $time, got.prime, got.finished, got.position);
            return;
        end
        want = awaited_primes.pop_front();
        if (got.prime !== want.prime) begin
            errors++;
            $display("%0t: prime expected %0d actual %0d", $time, want.prime, got.prime);
        end
        if (got.finished !== want.finished) begin
            errors++;
            $display("%0t: done_res expected %0d actual %0d", $time, want.finished,
                     got.finished);
        end
        if (got.position !== want.position) begin
            errors++;
            $display("%0t: prime_index expected %0d actual %0d", $time, want.position,
                     got.position);
        end
    endfunction
endclass

module testbench;
    import psg_pkg::*;

    localparam int unsigned SIEVE_SIZE  = 65536;
    localparam int unsigned CYCLE_LIMIT = 6000000;
    localparam int unsigned HOLD_CYCLES = 5000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   restart;
    logic                   out_valid;
    logic                   out_ready;
    logic [PRIME_W-1:0]     prime;
    logic                   done_res;
    logic [INDEX_W-1:0]     prime_index;

    sieve_tracker #(SIEVE_SIZE) tracker;
    sieve_answer_t              seen;
    idle_mode_t                 idle_mode;
    bit                         hold_request;

    prime_sieve_generator_top #(
        .SIEVE_SIZE(SIEVE_SIZE)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .prime      (prime),
        .done_res   (done_res),
        .prime_index(prime_index)
    );

    function automatic int unsigned idle_percent(idle_mode_t mode);
        case (mode)
            IDLE_SENDER, IDLE_RECEIVER: return 64;
            IDLE_BOTH:                  return 18;
            default:                    return 0;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{prime, done_res, prime_index};
            tracker.check_prime_transfer(seen);
        end
    end

    initial
    begin : receiver
        int unsigned held;
        out_ready = 1'b0;
        held      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                held         = HOLD_CYCLES;
            end
            if (held > 0)
            begin
                held--;
                out_ready <= 1'b0;
            end
            else if (idle_mode != IDLE_SENDER)
                out_ready <= ($urandom_range(0, 99) >= idle_percent(idle_mode));
            else
                out_ready <= 1'b1;
        end
    end

    task automatic offer_request(input bit clear_first);
        int unsigned gap;
        in_valid <= 1'b1;
        restart  <= clear_first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.predict_next_prime(clear_first);
        @(negedge clk);
        if (idle_mode != IDLE_RECEIVER && $urandom_range(0, 99) < idle_percent(idle_mode))
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 300)
                                              : $urandom_range(1, 6);
            in_valid <= 1'b0;
            restart  <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic await_answers();
        in_valid <= 1'b0;
        while (tracker.awaited_primes.size() != 0)
            @(posedge clk);
        repeat (tracker.settle_cycles) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_sieve(input int unsigned prime_total, input int unsigned limit_value);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRIME_COUNT;
        cfg_data  <= CFG_DATA_W'(prime_total[PRIME_COUNT_W-1:0]);
        tracker.write_reg(CFG_PRIME_COUNT, CFG_DATA_W'(prime_total[PRIME_COUNT_W-1:0]));
        @(negedge clk);
        cfg_index <= CFG_SIEVE_LIMIT;
        cfg_data  <= CFG_DATA_W'(limit_value);
        tracker.write_reg(CFG_SIEVE_LIMIT, CFG_DATA_W'(limit_value));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned sel;
        int unsigned prime_total;
        int unsigned limit_value;
        tracker = new();
        tracker.reset_state();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_PRIME_COUNT;
        cfg_data     = '0;
        in_valid     = 1'b0;
        restart      = 1'b0;
        idle_mode    = IDLE_NONE;
        hold_request = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register values out of reset, continuing without a restart.
        offer_request(1'b0);
        offer_request(1'b0);
        await_answers();

        // A limit above the sieve size is clipped to it.
        program_sieve(65535, 131071);
        offer_request(1'b1);
        await_answers();

        // Count reached, and the done answer repeats until a restart.
        program_sieve(5, 30);
        offer_request(1'b1);
        repeat (6) offer_request(1'b0);
        await_answers();

        program_sieve(3, 0);
        offer_request(1'b0);
        offer_request(1'b1);
        await_answers();

        program_sieve(3, 1);
        offer_request(1'b1);
        await_answers();

        program_sieve(0, 100);
        offer_request(1'b1);
        await_answers();

        program_sieve(65535, 3);
        offer_request(1'b1);
        offer_request(1'b0);
        await_answers();

        // Raising the limit mid-run keeps the shorter marks made before.
        program_sieve(10, 20);
        offer_request(1'b1);
        repeat (2) offer_request(1'b0);
        await_answers();
        program_sieve(9, 200);
        repeat (7) offer_request(1'b0);
        await_answers();

        for (int ph = 0; ph < 8; ph++)
        begin
            idle_mode = idle_mode_t'(ph % 4);
            sel = $urandom_range(0, 9);
            if (sel < 6)
                limit_value = $urandom_range(2, 200);
            else if (sel < 9)
                limit_value = $urandom_range(200, 2500);
            else
                limit_value = $urandom_range(2500, 5000);
            sel = $urandom_range(0, 9);
            if (sel < 7)
                prime_total = $urandom_range(1, 30);
            else if (sel == 7)
                prime_total = 0;
            else if (sel == 8)
                prime_total = 65535;
            else
                prime_total = $urandom_range(30, 400);
            program_sieve(prime_total, limit_value);
            if (ph == 2)
            begin
                @(posedge clk);
                hold_request = 1'b1;
                @(negedge clk);
            end
            for (int i = 0; i < 14; i++)
            begin
                if (ph == 5 && i == 9)
                    await_answers();
                if (i == 0)
                    offer_request(1'($urandom_range(0, 1)));
                else
                    offer_request($urandom_range(0, 7) == 0);
            end
            await_answers();
        end

        if (tracker.errors == 0 && tracker.awaited_primes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
